// ===== rtl/ttd_pkg.sv =====
package ttd_pkg;

	localparam logic [33:0] PI_Q32           = 34'h3_243F_6A89;
	localparam logic [31:0] ONE_Q30          = 32'h4000_0000;
	localparam logic [4:0]  TERM_COUNT_RESET = 5'd17;
	localparam logic [31:0] Q16_MAX          = 32'h7FFF_FFFF;
	localparam logic [31:0] Q16_MIN          = 32'h8000_0000;
	localparam logic [31:0] HALF_PI_Q30      = 32'd1686629713;

	// One transaction as it travels along the row of Taylor cells.
	typedef struct packed {
		logic               valid;
		logic [31:0]        ts;
		logic [31:0]        tc;
		logic [31:0]        x2;
		logic signed [33:0] s;
		logic signed [33:0] c;
		logic [4:0]         n;
		logic [30:0]        ax;
		logic               neg_x;
		logic               bad;
	} term_bus_t;

	typedef struct packed {
		logic       neg_x;
		logic       bad;
		logic [4:0] n;
	} rad_sb_t;

	typedef struct packed {
		logic        neg_q;
		logic        c_zero;
		logic        ovf;
		logic        s_neg;
		logic [30:0] ax;
		logic        neg_x;
		logic        bad;
	} tan_sb_t;

endpackage

// ===== rtl/ttd_angle_if.sv =====
interface ttd_angle_if;
	logic        valid;
	logic        ready;
	logic [16:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface

// ===== rtl/ttd_result_if.sv =====
interface ttd_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] tangent;
	logic [31:0] reduced_radians;
	logic        bad_angle;
	logic        saturated;

	modport source (output valid, output tangent, output reduced_radians,
		output bad_angle, output saturated, input ready);
	modport sink (input valid, input tangent, input reduced_radians,
		input bad_angle, input saturated, output ready);
endinterface

// ===== rtl/ttd_div_cell.sv =====
module ttd_div_cell #(
	parameter int DW  = 8,
	parameter int LW  = 31,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [DW-1:0]  in_rem,
	input  logic [LW-1:0]  in_lo,
	input  logic [LW-1:0]  in_q,
	input  logic [DW-1:0]  in_div,
	input  logic [SBW-1:0] in_sb,
	output logic           out_valid,
	output logic [DW-1:0]  out_rem,
	output logic [LW-1:0]  out_lo,
	output logic [LW-1:0]  out_q,
	output logic [DW-1:0]  out_div,
	output logic [SBW-1:0] out_sb
);
	logic [DW:0]   trial;
	logic          ge;
	logic [DW-1:0] nrem;

	// One restoring step: the remainder always stays below the divisor.
	always_comb begin
		trial = {in_rem, in_lo[LW-1]};
		ge    = trial >= {1'b0, in_div};
		nrem  = ge ? DW'(trial - {1'b0, in_div}) : trial[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem <= nrem;
			out_lo  <= {in_lo[LW-2:0], 1'b0};
			out_q   <= {in_q[LW-2:0], ge};
			out_div <= in_div;
			out_sb  <= in_sb;
		end
	end
endmodule

// ===== rtl/ttd_term_cell.sv =====
module ttd_term_cell #(
	parameter int K = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ttd_pkg::term_bus_t in_bus,
	output ttd_pkg::term_bus_t out_bus
);
	import ttd_pkg::*;

	localparam logic [31:0] SD  = 32'((2 * K) * (2 * K + 1));
	localparam logic [31:0] CD  = 32'((2 * K - 1) * (2 * K));
	localparam logic [63:0] SM64 = 64'h1_0000_0000 / 64'(SD);
	localparam logic [63:0] CM64 = 64'h1_0000_0000 / 64'(CD);
	localparam logic [31:0] SM  = 32'(SM64);
	localparam logic [31:0] CM  = 32'(CM64);
	localparam bit          ODD = (K % 2) == 1;

	term_bus_t   bus_s1, bus_s2, bus_s3;
	logic        v_s1, v_s2, v_s3;
	logic [31:0] ys_s1, yc_s1, ys_s2, yc_s2, qs_s2, qc_s2;
	logic [63:0] ps, pc, ms, mc;
	logic [31:0] rs, rc, ts_new, tc_new;
	logic        add;
	term_bus_t   nxt;

	always_comb begin
		ps = 64'(in_bus.ts) * 64'(in_bus.x2);
		pc = 64'(in_bus.tc) * 64'(in_bus.x2);
	end

	// Quotient estimate by reciprocal; it is exact or one low.
	always_comb begin
		ms = 64'(ys_s1) * 64'(SM);
		mc = 64'(yc_s1) * 64'(CM);
	end

	always_comb begin
		rs     = ys_s2 - 32'(qs_s2 * SD);
		rc     = yc_s2 - 32'(qc_s2 * CD);
		ts_new = qs_s2 + 32'(rs >= SD);
		tc_new = qc_s2 + 32'(rc >= CD);
		add    = bus_s2.n > 5'(K);
		nxt    = bus_s2;
		nxt.ts = ts_new;
		nxt.tc = tc_new;
		if (add) begin
			if (ODD) begin
				nxt.s = bus_s2.s - $signed({2'b00, ts_new});
				nxt.c = bus_s2.c - $signed({2'b00, tc_new});
			end else begin
				nxt.s = bus_s2.s + $signed({2'b00, ts_new});
				nxt.c = bus_s2.c + $signed({2'b00, tc_new});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_bus.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bus_s1 <= in_bus;
			ys_s1  <= ps[61:30];
			yc_s1  <= pc[61:30];
			bus_s2 <= bus_s1;
			ys_s2  <= ys_s1;
			yc_s2  <= yc_s1;
			qs_s2  <= ms[63:32];
			qc_s2  <= mc[63:32];
			bus_s3 <= nxt;
		end
	end

	always_comb begin
		out_bus       = bus_s3;
		out_bus.valid = v_s3;
	end
endmodule

// ===== rtl/tangent_taylor_degrees.sv =====
// Tangent of an angle in degrees by Taylor series of sine and cosine.
// The angle_ch channel carries one unsigned angle per transaction, with
// ANGLE_FRAC_BITS fraction bits. The result_ch channel returns one result per
// angle, in order: tan in Q16.16 (saturated, with a flag), the folded angle in
// radians in Q2.30, and a flag for angles of exactly 90, 270 or above 360.
// term_count (written through term_count_we/term_count_wdata) selects how many
// terms are summed; it resets to 17 and should be changed only while idle.
// The block is one pipeline: a fold stage, two multiply stages that form the
// radians, a squaring stage, MAX_TERMS-1 Taylor cells of three stages each, a
// sign stage, 32 cells of quotient division and an output register. One
// angle is taken each cycle unless the pipeline holds. Reset empties the
// pipeline. When the receiver stalls with a result waiting, the whole
// pipeline holds and angle_ch.ready drops.
module tangent_taylor_degrees #(
	parameter int MAX_TERMS       = 17,
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  term_count_we,
	input  logic [4:0]            term_count_wdata,
	ttd_angle_if.sink             angle_ch,
	ttd_result_if.source          result_ch
);
	import ttd_pkg::*;

	localparam int          F       = ANGLE_FRAC_BITS;
	localparam int          MAG_W   = $clog2(90 << F);
	localparam int          YW      = MAG_W + F + 10;
	localparam int          ZW      = MAG_W + 6;
	localparam int          TC      = 32;
	localparam int          TSBW    = $bits(tan_sb_t);
	localparam logic [63:0] DEN     = 64'(180) << (F + 2);
	localparam logic [63:0] RAD_A   = 64'(PI_Q32) / DEN;
	localparam logic [63:0] RAD_B   = 64'(PI_Q32) % DEN;
	localparam logic [31:0] RECIP45 = 32'((64'h1_0000_0000 + 64'd44) / 64'd45);
	localparam logic [31:0] L90     = 32'(90 << F);
	localparam logic [31:0] L180    = 32'(180 << F);
	localparam logic [31:0] L270    = 32'(270 << F);
	localparam logic [31:0] L360    = 32'(360 << F);
	localparam logic [4:0]  NMAX    = 5'(MAX_TERMS);

	logic             adv;
	logic [4:0]       term_count_q;
	logic [4:0]       n_in;
	logic [31:0]      a32;
	logic [31:0]      mag32;
	logic             neg_in, bad_in;

	logic             v_s1, v_s2, v_s3, v_s5, out_valid_q;
	logic [MAG_W-1:0] mag_s1;
	rad_sb_t          rsb_s1, rsb_s2, rsb_s3;
	logic [31:0]      ma;
	logic [YW-1:0]    yb;
	logic [31:0]      ma_s2;
	logic [ZW-1:0]    z_s2;
	logic [63:0]      zprod;
	logic [31:0]      ax_n;
	logic [30:0]      ax_s3;

	logic [61:0]      sq;
	term_bus_t        head_s4;
	term_bus_t        chain [MAX_TERMS];
	term_bus_t        tail;

	logic signed [33:0] sf_s5, c_s5;
	tan_sb_t            tsb_s5;
	logic [33:0]        us, uc;
	tan_sb_t            tsb0;

	logic             tv   [TC+1];
	logic [33:0]      trem [TC+1];
	logic [TC-1:0]    tlo  [TC+1];
	logic [TC-1:0]    tq   [TC+1];
	logic [33:0]      tdiv [TC+1];
	logic [TSBW-1:0]  tsb  [TC+1];

	tan_sb_t          tsb_end;
	logic [31:0]      qv;
	logic [31:0]      tan_n, red_n;
	logic             sat_n;
	logic [31:0]      tan_q, red_q;
	logic             bad_q, sat_q;

	assign adv            = !out_valid_q || result_ch.ready;
	assign angle_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_COUNT_RESET;
		end else if (term_count_we) begin
			term_count_q <= term_count_wdata;
		end
	end

	// Fold into (-90, 90) degrees as a magnitude and a sign.
	always_comb begin
		a32    = 32'(angle_ch.angle);
		mag32  = '0;
		neg_in = 1'b0;
		bad_in = 1'b0;
		if (a32 < L90) begin
			mag32 = a32;
		end else if (a32 > L90 && a32 < L180) begin
			mag32  = L180 - a32;
			neg_in = 1'b1;
		end else if (a32 >= L180 && a32 < L270) begin
			mag32 = a32 - L180;
		end else if (a32 > L270 && a32 <= L360) begin
			mag32  = L360 - a32;
			neg_in = a32 != L360;
		end else begin
			bad_in = 1'b1;
		end
		if (term_count_q == 5'd0) begin
			n_in = 5'd1;
		end else if (term_count_q > NMAX) begin
			n_in = NMAX;
		end else begin
			n_in = term_count_q;
		end
	end

	// Rounded radians: with pi*2^32 = DEN*A + B, the result is
	// mag*A + floor((mag*B + DEN/2) / DEN). DEN is 45 * 2^(F+4), so the
	// remaining division is a shift and a reciprocal multiply by 1/45,
	// which is exact over the whole range of the shifted value.
	assign ma    = 32'(mag_s1) * 32'(RAD_A);
	assign yb    = YW'(mag_s1) * YW'(RAD_B) + YW'(DEN >> 1);
	assign zprod = 64'(z_s2) * 64'(RECIP45);
	assign ax_n  = ma_s2 + zprod[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= angle_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s5 <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1       <= MAG_W'(mag32);
			rsb_s1.neg_x <= neg_in;
			rsb_s1.bad   <= bad_in;
			rsb_s1.n     <= n_in;
			ma_s2        <= ma;
			z_s2         <= ZW'(yb >> (F + 4));
			rsb_s2       <= rsb_s1;
			ax_s3        <= ax_n[30:0];
			rsb_s3       <= rsb_s2;
		end
	end

	assign sq = 62'(ax_s3) * 62'(ax_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_s4 <= '0;
		end else if (adv) begin
			head_s4 <= '{
				valid: v_s3,
				ts:    32'(ax_s3),
				tc:    ONE_Q30,
				x2:    sq[61:30],
				s:     $signed({3'b000, ax_s3}),
				c:     $signed({2'b00, ONE_Q30}),
				n:     rsb_s3.n,
				ax:    ax_s3,
				neg_x: rsb_s3.neg_x,
				bad:   rsb_s3.bad
			};
		end
	end

	assign chain[0] = head_s4;

	for (genvar k = 1; k < MAX_TERMS; k++) begin : g_term
		ttd_term_cell #(.K(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.in_bus (chain[k-1]),
			.out_bus(chain[k])
		);
	end

	assign tail = chain[MAX_TERMS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sf_s5  <= tail.neg_x ? -tail.s : tail.s;
			c_s5   <= tail.c;
			tsb_s5 <= '{
				neg_q:  1'b0,
				c_zero: 1'b0,
				ovf:    1'b0,
				s_neg:  1'b0,
				ax:     tail.ax,
				neg_x:  tail.neg_x,
				bad:    tail.bad
			};
		end
	end

	// Quotient set-up: the quotient is used only when it fits 32 bits; else ovf saturates it.
	always_comb begin
		us            = sf_s5[33] ? 34'(-sf_s5) : 34'(sf_s5);
		uc            = c_s5[33] ? 34'(-c_s5) : 34'(c_s5);
		tsb0          = tsb_s5;
		tsb0.s_neg    = sf_s5[33];
		tsb0.neg_q    = sf_s5[33] != c_s5[33];
		tsb0.c_zero   = c_s5 == '0;
		tsb0.ovf      = {16'b0, us} >= {uc, 16'b0};
	end

	assign tv[0]   = v_s5;
	assign trem[0] = tsb0.ovf ? '0 : (us >> 16);
	assign tlo[0]  = {us[15:0], 16'b0};
	assign tq[0]   = '0;
	assign tdiv[0] = uc;
	assign tsb[0]  = tsb0;

	for (genvar j = 0; j < TC; j++) begin : g_quo
		ttd_div_cell #(.DW(34), .LW(TC), .SBW(TSBW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_valid (tv[j]),
			.in_rem   (trem[j]),
			.in_lo    (tlo[j]),
			.in_q     (tq[j]),
			.in_div   (tdiv[j]),
			.in_sb    (tsb[j]),
			.out_valid(tv[j+1]),
			.out_rem  (trem[j+1]),
			.out_lo   (tlo[j+1]),
			.out_q    (tq[j+1]),
			.out_div  (tdiv[j+1]),
			.out_sb   (tsb[j+1])
		);
	end

	assign tsb_end = tan_sb_t'(tsb[TC]);
	assign qv      = tq[TC];

	always_comb begin
		sat_n = 1'b0;
		red_n = tsb_end.neg_x ? 32'(-{1'b0, tsb_end.ax}) : {1'b0, tsb_end.ax};
		if (tsb_end.c_zero) begin
			sat_n = 1'b1;
			tan_n = tsb_end.s_neg ? Q16_MIN : Q16_MAX;
		end else if (tsb_end.neg_q) begin
			if (tsb_end.ovf || qv > Q16_MIN) begin
				sat_n = 1'b1;
				tan_n = Q16_MIN;
			end else begin
				tan_n = 32'(0) - qv;
			end
		end else if (tsb_end.ovf || qv[31]) begin
			sat_n = 1'b1;
			tan_n = Q16_MAX;
		end else begin
			tan_n = qv;
		end
		if (tsb_end.bad) begin
			sat_n = 1'b0;
			tan_n = '0;
			red_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tv[TC];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tan_q <= tan_n;
			red_q <= red_n;
			bad_q <= tsb_end.bad;
			sat_q <= sat_n;
		end
	end

	assign result_ch.valid           = out_valid_q;
	assign result_ch.tangent         = tan_q;
	assign result_ch.reduced_radians = red_q;
	assign result_ch.bad_angle       = bad_q;
	assign result_ch.saturated       = sat_q;

`ifndef SYNTHESIS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bad_q |-> tan_q == '0 && red_q == '0 && !sat_q)
		else $error("bad angle result carries nonzero fields");

	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sat_q |-> tan_q == Q16_MAX || tan_q == Q16_MIN)
		else $error("saturated result is not clamped");

	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (red_q[31] ? 32'(-red_q) : red_q) <= HALF_PI_Q30)
		else $error("folded radians outside half pi");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(tv[TC]) && $stable(v_s5))
		else $error("pipeline moved while output stalled");
`endif
endmodule
